FILE: design/dsfa_pkg.sv
// ----------------------------------------------------------------------------
// Dust sensor frame averager package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dsfa_pkg;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [1:0] CFG_READINGS = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;

    localparam logic [7:0]  READINGS_RESET = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1200;
    localparam logic [7:0]  LIMIT_RESET    = 8'd2;

    localparam logic [7:0] HEAD_BYTE = 8'hAA;
    localparam logic [7:0] CMD_BYTE  = 8'hC0;
    localparam logic [7:0] TAIL_BYTE = 8'hAB;

    localparam logic [3:0] POS_HEAD    = 4'd0;
    localparam logic [3:0] POS_CMD     = 4'd1;
    localparam logic [3:0] POS_PM25_LO = 4'd2;
    localparam logic [3:0] POS_PM25_HI = 4'd3;
    localparam logic [3:0] POS_PM10_LO = 4'd4;
    localparam logic [3:0] POS_PM10_HI = 4'd5;
    localparam logic [3:0] POS_SPARE_0 = 4'd6;
    localparam logic [3:0] POS_SPARE_1 = 4'd7;
    localparam logic [3:0] POS_CHECK   = 4'd8;
    localparam logic [3:0] POS_TAIL    = 4'd9;

    localparam int          TOTAL_W   = 24;
    localparam logic [4:0]  DIV_LAST  = 5'd23;

    typedef struct packed {
        logic step;
        logic div_run;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic has_result;
        logic need_div;
        logic div_done;
    } status_t;

endpackage

FILE: design/dsfa_ctrl.sv
// ----------------------------------------------------------------------------
// Dust sensor frame averager controller
// Sequences request intake, the serial division and the output register.
// ----------------------------------------------------------------------------
module dsfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  dsfa_pkg::status_t status,
    output dsfa_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step = 1'b1;
                    if (status.need_div)
                    begin
                        state_next = ST_DIVIDE;
                    end
                    else if (status.has_result)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_run = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/dsfa_datapath.sv
// ----------------------------------------------------------------------------
// Dust sensor frame averager datapath
// Frame parser, run counters, serial divider and output register.
// ----------------------------------------------------------------------------
module dsfa_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [1:0]        mode,
    input  logic [7:0]        data_byte,
    input  dsfa_pkg::cmd_t    cmd,
    output dsfa_pkg::status_t status,
    output logic              frame_ok,
    output logic [15:0]       pm25_raw,
    output logic [15:0]       pm10_raw,
    output logic              run_done,
    output logic              run_ok,
    output logic [15:0]       pm25_average,
    output logic [15:0]       pm10_average
);

    localparam int TW = dsfa_pkg::TOTAL_W;

    logic [7:0]    readings_reg;
    logic [15:0]   timeout_reg;
    logic [7:0]    limit_reg;

    logic [3:0]    pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic [15:0]   pm25_frame_reg, pm25_frame_next;
    logic [15:0]   pm10_frame_reg, pm10_frame_next;
    logic [7:0]    check_reg, check_next;
    logic          active_reg, active_next;
    logic [7:0]    good_reg, good_next;
    logic [7:0]    fail_reg, fail_next;
    logic [TW-1:0] pm25_total_reg, pm25_total_next;
    logic [TW-1:0] pm10_total_reg, pm10_total_next;
    logic [15:0]   ticks_reg, ticks_next;

    logic          res_frame_reg, res_frame_next;
    logic [15:0]   res_pm25_reg, res_pm25_next;
    logic [15:0]   res_pm10_reg, res_pm10_next;
    logic          res_done_reg, res_done_next;
    logic          res_ok_reg, res_ok_next;

    logic [TW-1:0] q25_reg, q25_next;
    logic [TW-1:0] q10_reg, q10_next;
    logic [7:0]    rem25_reg, rem25_next;
    logic [7:0]    rem10_reg, rem10_next;
    logic [7:0]    divisor_reg, divisor_next;
    logic [4:0]    div_count_reg, div_count_next;

    logic [7:0]    need;
    logic [7:0]    limit;
    logic [15:0]   ticks_inc;
    logic [7:0]    fail_inc;
    logic [7:0]    good_inc;
    logic          good_frame;
    logic [8:0]    shift25;
    logic [8:0]    shift10;
    logic          ge25;
    logic          ge10;

    assign need  = (readings_reg == 8'd0) ? 8'd1 : readings_reg;
    assign limit = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
    assign ticks_inc = ticks_reg + 16'd1;
    assign fail_inc  = fail_reg + 8'd1;
    assign good_inc  = good_reg + 8'd1;

    // The next state is worked out for the request on the input every cycle;
    // the registers take it only when the controller steps.
    always_comb
    begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        pm25_frame_next = pm25_frame_reg;
        pm10_frame_next = pm10_frame_reg;
        check_next      = check_reg;
        active_next     = active_reg;
        good_next       = good_reg;
        fail_next       = fail_reg;
        pm25_total_next = pm25_total_reg;
        pm10_total_next = pm10_total_reg;
        ticks_next      = ticks_reg;
        res_frame_next  = 1'b0;
        res_pm25_next   = 16'd0;
        res_pm10_next   = 16'd0;
        res_done_next   = 1'b0;
        res_ok_next     = 1'b0;
        good_frame      = 1'b0;
        status          = '0;

        case (mode)
            dsfa_pkg::MODE_START:
            begin
                active_next     = 1'b1;
                good_next       = 8'd0;
                fail_next       = 8'd0;
                pm25_total_next = '0;
                pm10_total_next = '0;
                ticks_next      = 16'd0;
            end
            dsfa_pkg::MODE_TICK:
            begin
                if (active_reg)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_reg)
                    begin
                        ticks_next = 16'd0;
                        fail_next  = fail_inc;
                        if (fail_inc >= limit)
                        begin
                            active_next       = 1'b0;
                            res_done_next     = 1'b1;
                            status.has_result = 1'b1;
                        end
                    end
                end
            end
            dsfa_pkg::MODE_BYTE:
            begin
                case (pos_reg) inside
                    dsfa_pkg::POS_HEAD:
                    begin
                        if (data_byte == dsfa_pkg::HEAD_BYTE)
                        begin
                            sum_next = 8'd0;
                            pos_next = dsfa_pkg::POS_CMD;
                        end
                    end
                    dsfa_pkg::POS_CMD:
                    begin
                        pos_next = (data_byte == dsfa_pkg::CMD_BYTE) ?
                                   dsfa_pkg::POS_PM25_LO : dsfa_pkg::POS_HEAD;
                    end
                    [dsfa_pkg::POS_PM25_LO:dsfa_pkg::POS_SPARE_1]:
                    begin
                        if (pos_reg == dsfa_pkg::POS_PM25_LO)
                        begin
                            pm25_frame_next = {pm25_frame_reg[15:8], data_byte};
                        end
                        if (pos_reg == dsfa_pkg::POS_PM25_HI)
                        begin
                            pm25_frame_next = {data_byte, pm25_frame_reg[7:0]};
                        end
                        if (pos_reg == dsfa_pkg::POS_PM10_LO)
                        begin
                            pm10_frame_next = {pm10_frame_reg[15:8], data_byte};
                        end
                        if (pos_reg == dsfa_pkg::POS_PM10_HI)
                        begin
                            pm10_frame_next = {data_byte, pm10_frame_reg[7:0]};
                        end
                        sum_next = sum_reg + data_byte;
                        pos_next = pos_reg + 4'd1;
                    end
                    dsfa_pkg::POS_CHECK:
                    begin
                        check_next = data_byte;
                        pos_next   = dsfa_pkg::POS_TAIL;
                    end
                    default:
                    begin
                        good_frame = (data_byte == dsfa_pkg::TAIL_BYTE) &&
                                     (sum_reg == check_reg);
                        pos_next   = dsfa_pkg::POS_HEAD;
                    end
                endcase

                if (good_frame)
                begin
                    status.has_result = 1'b1;
                    res_frame_next    = 1'b1;
                    res_pm25_next     = pm25_frame_reg;
                    res_pm10_next     = pm10_frame_reg;
                    if (active_reg)
                    begin
                        pm25_total_next = pm25_total_reg + {8'd0, pm25_frame_reg};
                        pm10_total_next = pm10_total_reg + {8'd0, pm10_frame_reg};
                        good_next       = good_inc;
                        ticks_next      = 16'd0;
                        if (good_inc >= need)
                        begin
                            active_next     = 1'b0;
                            res_done_next   = 1'b1;
                            res_ok_next     = 1'b1;
                            status.need_div = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        status.div_done = (div_count_reg == dsfa_pkg::DIV_LAST);
    end

    // Restoring division of both totals by the same divisor, one bit per cycle.
    assign shift25 = {rem25_reg, q25_reg[TW-1]};
    assign shift10 = {rem10_reg, q10_reg[TW-1]};
    assign ge25    = (shift25 >= {1'b0, divisor_reg});
    assign ge10    = (shift10 >= {1'b0, divisor_reg});

    always_comb
    begin
        q25_next       = q25_reg;
        q10_next       = q10_reg;
        rem25_next     = rem25_reg;
        rem10_next     = rem10_reg;
        divisor_next   = divisor_reg;
        div_count_next = div_count_reg;
        if (cmd.step)
        begin
            q25_next       = pm25_total_next;
            q10_next       = pm10_total_next;
            rem25_next     = 8'd0;
            rem10_next     = 8'd0;
            divisor_next   = need;
            div_count_next = 5'd0;
        end
        else if (cmd.div_run)
        begin
            q25_next       = {q25_reg[TW-2:0], ge25};
            q10_next       = {q10_reg[TW-2:0], ge10};
            rem25_next     = ge25 ? 8'(shift25 - {1'b0, divisor_reg}) : shift25[7:0];
            rem10_next     = ge10 ? 8'(shift10 - {1'b0, divisor_reg}) : shift10[7:0];
            div_count_next = div_count_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            readings_reg   <= dsfa_pkg::READINGS_RESET;
            timeout_reg    <= dsfa_pkg::TIMEOUT_RESET;
            limit_reg      <= dsfa_pkg::LIMIT_RESET;
            pos_reg        <= dsfa_pkg::POS_HEAD;
            sum_reg        <= 8'd0;
            pm25_frame_reg <= 16'd0;
            pm10_frame_reg <= 16'd0;
            check_reg      <= 8'd0;
            active_reg     <= 1'b0;
            good_reg       <= 8'd0;
            fail_reg       <= 8'd0;
            pm25_total_reg <= '0;
            pm10_total_reg <= '0;
            ticks_reg      <= 16'd0;
            div_count_reg  <= 5'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    dsfa_pkg::CFG_READINGS: readings_reg <= cfg_data[7:0];
                    dsfa_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                    dsfa_pkg::CFG_LIMIT:    limit_reg    <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.step)
            begin
                pos_reg        <= pos_next;
                sum_reg        <= sum_next;
                pm25_frame_reg <= pm25_frame_next;
                pm10_frame_reg <= pm10_frame_next;
                check_reg      <= check_next;
                active_reg     <= active_next;
                good_reg       <= good_next;
                fail_reg       <= fail_next;
                pm25_total_reg <= pm25_total_next;
                pm10_total_reg <= pm10_total_next;
                ticks_reg      <= ticks_next;
            end
            div_count_reg  <= div_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            res_frame_reg <= res_frame_next;
            res_pm25_reg  <= res_pm25_next;
            res_pm10_reg  <= res_pm10_next;
            res_done_reg  <= res_done_next;
            res_ok_reg    <= res_ok_next;
        end
        q25_reg       <= q25_next;
        q10_reg       <= q10_next;
        rem25_reg     <= rem25_next;
        rem10_reg     <= rem10_next;
        divisor_reg   <= divisor_next;
        if (cmd.out_load)
        begin
            frame_ok     <= res_frame_reg;
            pm25_raw     <= res_pm25_reg;
            pm10_raw     <= res_pm10_reg;
            run_done     <= res_done_reg;
            run_ok       <= res_ok_reg;
            pm25_average <= res_ok_reg ? q25_reg[15:0] : 16'd0;
            pm10_average <= res_ok_reg ? q10_reg[15:0] : 16'd0;
        end
    end

endmodule

FILE: design/dust_sensor_frame_averager_top.sv
// ----------------------------------------------------------------------------
// Dust sensor frame averager
// Parses particulate-sensor frames and averages readings over a run.
// ----------------------------------------------------------------------------
// Each input request carries a mode and a data byte: a received serial byte,
// a one millisecond tick, or a start of an averaging run. A request is taken
// when in_valid is high and in_stall is low. A result request leaves on the
// output channel when a byte completes a good frame or when a run ends.
// A request that causes no result leaves in_stall low. A request that
// yields a result without an average goes from ST_IDLE to ST_EMIT and is
// loaded into the output register from there; one that ends a successful
// run first passes through ST_DIVIDE, where the serial divider, which shares
// one bit step per cycle for both averages, works through the 24-bit totals.
// From the cycle after a request with a result is taken until that result
// enters the output register, in_stall is high; a full output register that
// is stalled extends this. The output register keeps its request while
// out_stall is high, and the next request can be taken meanwhile.
// Configuration writes through cfg_write, cfg_index and cfg_data bypass the
// request handshake. Reset clears the parser, the run and the output
// channel and loads the register defaults.
// ----------------------------------------------------------------------------
module dust_sensor_frame_averager_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_ok,
    output logic [15:0] pm25_raw,
    output logic [15:0] pm10_raw,
    output logic        run_done,
    output logic        run_ok,
    output logic [15:0] pm25_average,
    output logic [15:0] pm10_average
);

    dsfa_pkg::cmd_t    cmd;
    dsfa_pkg::status_t status;

    dsfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dsfa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .status       (status),
        .frame_ok     (frame_ok),
        .pm25_raw     (pm25_raw),
        .pm10_raw     (pm10_raw),
        .run_done     (run_done),
        .run_ok       (run_ok),
        .pm25_average (pm25_average),
        .pm10_average (pm10_average)
    );

endmodule

FILE: verif/tb_dust_sensor_frame_averager_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dust sensor frame averager regression
// Drives serial bytes, millisecond ticks and run starts through the request
// handshake. A shadow copy of the parser and run state predicts each report,
// and every accepted output request is checked field by field against the
// oldest prediction. Directed tests cover frame faults, timeouts, restarts,
// back pressure and a long run; random traffic runs under several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_dust_sensor_frame_averager_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        frame_ok;
        logic [15:0] pm25_raw;
        logic [15:0] pm10_raw;
        logic        run_done;
        logic        run_ok;
        logic [15:0] pm25_average;
        logic [15:0] pm10_average;
    } report_t;

    typedef enum logic [2:0] {
        FRAME_CLEAN,
        FRAME_BAD_HEAD,
        FRAME_BAD_COMMAND,
        FRAME_BAD_CHECK,
        FRAME_BAD_TAIL,
        FRAME_CUT_SHORT
    } frame_flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = dsfa_pkg::CFG_READINGS;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_mode = dsfa_pkg::MODE_BYTE;
    logic [7:0]  req_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        frame_ok;
    logic [15:0] pm25_raw;
    logic [15:0] pm10_raw;
    logic        run_done;
    logic        run_ok;
    logic [15:0] pm25_average;
    logic [15:0] pm10_average;

    logic [7:0]  cfg_readings = dsfa_pkg::READINGS_RESET;
    logic [15:0] cfg_timeout = dsfa_pkg::TIMEOUT_RESET;
    logic [7:0]  cfg_limit = dsfa_pkg::LIMIT_RESET;

    logic [3:0]  parse_pos = dsfa_pkg::POS_HEAD;
    logic [7:0]  frame_sum = '0;
    logic [15:0] frame_pm25 = '0;
    logic [15:0] frame_pm10 = '0;
    logic [7:0]  frame_check = '0;
    logic        run_on = 1'b0;
    logic [7:0]  good_frames = '0;
    logic [7:0]  failed_attempts = '0;
    logic [23:0] pm25_sum = '0;
    logic [23:0] pm10_sum = '0;
    logic [15:0] tick_count = '0;

    report_t pending_reports[$];
    int counted_requests = 0;
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    dust_sensor_frame_averager_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (req_mode),
        .data_byte    (req_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_ok     (frame_ok),
        .pm25_raw     (pm25_raw),
        .pm10_raw     (pm10_raw),
        .run_done     (run_done),
        .run_ok       (run_ok),
        .pm25_average (pm25_average),
        .pm10_average (pm10_average)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dust_sensor_frame_averager_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Returns true when this byte completes a frame with a good check and tail.
    function automatic logic parse_frame_byte(input logic [7:0] b);
        logic good;
        good = 1'b0;
        case (parse_pos)
            dsfa_pkg::POS_HEAD:
            begin
                if (b == dsfa_pkg::HEAD_BYTE)
                begin
                    frame_sum = '0;
                    parse_pos = dsfa_pkg::POS_CMD;
                end
            end
            dsfa_pkg::POS_CMD:
            begin
                parse_pos = (b == dsfa_pkg::CMD_BYTE) ? dsfa_pkg::POS_PM25_LO
                                                      : dsfa_pkg::POS_HEAD;
            end
            dsfa_pkg::POS_CHECK:
            begin
                frame_check = b;
                parse_pos = dsfa_pkg::POS_TAIL;
            end
            dsfa_pkg::POS_TAIL:
            begin
                good = (b == dsfa_pkg::TAIL_BYTE) && (frame_sum == frame_check);
                parse_pos = dsfa_pkg::POS_HEAD;
            end
            default:
            begin
                if (parse_pos == dsfa_pkg::POS_PM25_LO)
                    frame_pm25[7:0] = b;
                else if (parse_pos == dsfa_pkg::POS_PM25_HI)
                    frame_pm25[15:8] = b;
                else if (parse_pos == dsfa_pkg::POS_PM10_LO)
                    frame_pm10[7:0] = b;
                else if (parse_pos == dsfa_pkg::POS_PM10_HI)
                    frame_pm10[15:8] = b;
                frame_sum = frame_sum + b;
                parse_pos = parse_pos + 4'd1;
            end
        endcase
        return good;
    endfunction

    task automatic advance_averager(input logic [1:0] m, input logic [7:0] b);
        logic [7:0] need;
        logic [7:0] limit;
        report_t rep;
        need = (cfg_readings == 8'd0) ? 8'd1 : cfg_readings;
        limit = (cfg_limit == 8'd0) ? 8'd1 : cfg_limit;
        rep = '0;
        if (m == dsfa_pkg::MODE_BYTE || m == dsfa_pkg::MODE_START ||
            (m == dsfa_pkg::MODE_TICK && run_on))
            counted_requests++;
        case (m)
            dsfa_pkg::MODE_START:
            begin
                run_on = 1'b1;
                good_frames = '0;
                failed_attempts = '0;
                pm25_sum = '0;
                pm10_sum = '0;
                tick_count = '0;
            end
            dsfa_pkg::MODE_TICK:
            begin
                if (run_on)
                begin
                    tick_count = tick_count + 16'd1;
                    if (tick_count >= cfg_timeout)
                    begin
                        tick_count = '0;
                        failed_attempts = failed_attempts + 8'd1;
                        if (failed_attempts >= limit)
                        begin
                            run_on = 1'b0;
                            rep.run_done = 1'b1;
                            pending_reports.push_back(rep);
                        end
                    end
                end
            end
            dsfa_pkg::MODE_BYTE:
            begin
                if (parse_frame_byte(b))
                begin
                    rep.frame_ok = 1'b1;
                    rep.pm25_raw = frame_pm25;
                    rep.pm10_raw = frame_pm10;
                    if (run_on)
                    begin
                        pm25_sum = pm25_sum + {8'd0, frame_pm25};
                        pm10_sum = pm10_sum + {8'd0, frame_pm10};
                        good_frames = good_frames + 8'd1;
                        tick_count = '0;
                        if (good_frames >= need)
                        begin
                            run_on = 1'b0;
                            rep.run_done = 1'b1;
                            rep.run_ok = 1'b1;
                            rep.pm25_average = 16'(pm25_sum / need);
                            rep.pm10_average = 16'(pm10_sum / need);
                        end
                    end
                    pending_reports.push_back(rep);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                error_count++;
                $display("%0t ns: report expected none actual frame_ok %0b run_done %0b",
                         $time, frame_ok, run_done);
            end
            else
            begin
                check_field("frame_ok", pending_reports[0].frame_ok, frame_ok);
                check_field("pm25_raw", pending_reports[0].pm25_raw, pm25_raw);
                check_field("pm10_raw", pending_reports[0].pm10_raw, pm10_raw);
                check_field("run_done", pending_reports[0].run_done, run_done);
                check_field("run_ok", pending_reports[0].run_ok, run_ok);
                check_field("pm25_average", pending_reports[0].pm25_average, pm25_average);
                check_field("pm10_average", pending_reports[0].pm10_average, pm10_average);
                void'(pending_reports.pop_front());
            end
        end
    end

    task automatic send_request(input logic [1:0] m, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_mode <= m;
        req_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_averager(m, b);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_request(dsfa_pkg::MODE_TICK, 8'($urandom));
    endtask

    task automatic send_frame(input logic [15:0] pm25, input logic [15:0] pm10,
                              input frame_flaw_t flaw);
        logic [7:0] frame_bytes [10];
        logic [7:0] flip;
        int length;
        frame_bytes[0] = dsfa_pkg::HEAD_BYTE;
        frame_bytes[1] = dsfa_pkg::CMD_BYTE;
        frame_bytes[2] = pm25[7:0];
        frame_bytes[3] = pm25[15:8];
        frame_bytes[4] = pm10[7:0];
        frame_bytes[5] = pm10[15:8];
        frame_bytes[6] = 8'($urandom);
        frame_bytes[7] = 8'($urandom);
        frame_bytes[8] = frame_bytes[2] + frame_bytes[3] + frame_bytes[4]
                       + frame_bytes[5] + frame_bytes[6] + frame_bytes[7];
        frame_bytes[9] = dsfa_pkg::TAIL_BYTE;
        length = 10;
        do
            flip = 8'($urandom);
        while (flip == 8'd0);
        case (flaw)
            FRAME_BAD_HEAD:    frame_bytes[0] = frame_bytes[0] ^ flip;
            FRAME_BAD_COMMAND: frame_bytes[1] = frame_bytes[1] ^ flip;
            FRAME_BAD_CHECK:   frame_bytes[8] = frame_bytes[8] ^ flip;
            FRAME_BAD_TAIL:    frame_bytes[9] = frame_bytes[9] ^ flip;
            FRAME_CUT_SHORT:   length = $urandom_range(2, 9);
            default:
            begin
            end
        endcase
        for (int i = 0; i < length; i++)
            send_request(dsfa_pkg::MODE_BYTE, frame_bytes[i]);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Upper data bits of the 8-bit registers carry noise that must be dropped.
    task automatic configure(input logic [7:0] readings, input logic [15:0] timeout,
                             input logic [7:0] limit);
        write_register(dsfa_pkg::CFG_READINGS, {8'($urandom), readings});
        cfg_readings = readings;
        write_register(dsfa_pkg::CFG_TIMEOUT, timeout);
        cfg_timeout = timeout;
        write_register(dsfa_pkg::CFG_LIMIT, {8'($urandom), limit});
        cfg_limit = limit;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [15:0] random_reading();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_single_reading_defaults();
        send_frame(16'hFFFF, 16'h0000, FRAME_CLEAN);
        send_request(dsfa_pkg::MODE_START, 8'hFF);
        send_frame(16'h0000, 16'hFFFF, FRAME_CLEAN);
        settle();
    endtask

    task automatic test_malformed_frames();
        send_request(dsfa_pkg::MODE_BYTE, 8'h55);
        send_request(dsfa_pkg::MODE_BYTE, dsfa_pkg::HEAD_BYTE);
        send_request(dsfa_pkg::MODE_BYTE, 8'h3F);
        send_frame(16'h1234, 16'h5678, FRAME_BAD_CHECK);
        send_frame(16'h9ABC, 16'hDEF0, FRAME_BAD_TAIL);
        send_request(MODE_UNUSED, 8'hAA);
        send_request(dsfa_pkg::MODE_TICK, 8'h00);
        settle();
    endtask

    task automatic test_attempt_timeouts();
        configure(8'd0, 16'd0, 8'd0);
        send_request(dsfa_pkg::MODE_START, 8'h00);
        send_request(dsfa_pkg::MODE_TICK, 8'h00);
        send_request(dsfa_pkg::MODE_START, 8'h00);
        send_frame(16'h0101, 16'h0202, FRAME_CLEAN);
        settle();
        configure(8'd3, 16'd2, 8'd2);
        send_request(dsfa_pkg::MODE_START, 8'h00);
        send_ticks(4);
        send_request(dsfa_pkg::MODE_TICK, 8'h00);
        settle();
    endtask

    task automatic test_run_restart();
        configure(8'd3, dsfa_pkg::TIMEOUT_RESET, dsfa_pkg::LIMIT_RESET);
        send_request(dsfa_pkg::MODE_START, 8'h00);
        send_frame(16'd500, 16'd900, FRAME_CLEAN);
        send_request(dsfa_pkg::MODE_START, 8'h00);
        send_frame(16'd301, 16'd77, FRAME_CLEAN);
        settle();
        configure(8'd2, dsfa_pkg::TIMEOUT_RESET, dsfa_pkg::LIMIT_RESET);
        send_frame(16'd8, 16'd65535, FRAME_CLEAN);
        settle();
    endtask

    task automatic test_back_pressure();
        configure(8'd1, dsfa_pkg::TIMEOUT_RESET, dsfa_pkg::LIMIT_RESET);
        hold_left = 400;
        repeat (6)
        begin
            send_request(dsfa_pkg::MODE_START, 8'h00);
            send_frame(random_reading(), random_reading(), FRAME_CLEAN);
        end
        settle();
    endtask

    task automatic test_long_run();
        configure(8'd40, 16'd65535, 8'd255);
        send_request(dsfa_pkg::MODE_START, 8'h00);
        for (int i = 0; i < 40; i++)
        begin
            if (i % 10 == 0)
                send_ticks(3);
            send_frame(16'hFF00 | 16'($urandom), 16'($urandom), FRAME_CLEAN);
        end
        settle();
    endtask

    task automatic pick_random_settings();
        logic [7:0] readings;
        logic [15:0] timeout;
        logic [7:0] limit;
        readings = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
        timeout = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 1) * 65535)
                                           : 16'($urandom_range(1, 12));
        limit = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
        configure(readings, timeout, limit);
    endtask

    task automatic random_phase(input int idle_pct, input int busy_pct, input int count);
        int target;
        int next_settings;
        int pick;
        send_idle_pct = idle_pct;
        stall_pct = busy_pct;
        target = counted_requests + count;
        next_settings = counted_requests;
        while (counted_requests < target)
        begin
            if (counted_requests >= next_settings)
            begin
                settle();
                pick_random_settings();
                next_settings = counted_requests + 150;
            end
            pick = $urandom_range(99);
            if (pick < 55)
                send_frame(random_reading(), random_reading(), FRAME_CLEAN);
            else if (pick < 65)
                send_frame(random_reading(), random_reading(),
                           frame_flaw_t'($urandom_range(1, 5)));
            else if (pick < 77)
                send_ticks($urandom_range(1, 12));
            else if (pick < 85)
                send_request(dsfa_pkg::MODE_START, 8'($urandom));
            else if (pick < 95)
                send_request(dsfa_pkg::MODE_BYTE, 8'($urandom));
            else
                send_request(MODE_UNUSED, 8'($urandom));
        end
        settle();
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 300);
        random_phase(83, 0, 300);
        random_phase(0, 83, 300);
        random_phase(15, 15, 300);
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_reading_defaults();
        test_malformed_frames();
        test_attempt_timeouts();
        test_run_restart();
        test_back_pressure();
        test_long_run();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("dust_sensor_frame_averager_top regression: pass");
        else
            $display("dust_sensor_frame_averager_top regression: fail");
        $finish;
    end

endmodule

FILE: dust_sensor_frame_averager_top.f
design/dsfa_pkg.sv
design/dsfa_ctrl.sv
design/dsfa_datapath.sv
design/dust_sensor_frame_averager_top.sv
verif/tb_dust_sensor_frame_averager_top.sv
